[rtl/core/glo_pkg.sv]
// ----------------------------------------------------------------------------
// glo_pkg
// shared types, widths and codes for the grid line obstacle check block
// ----------------------------------------------------------------------------
package glo_pkg;

    // grid size, a power of two so that index wrap is a plain truncation
    localparam int GRID_CELLS = 65536;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int EXT_W      = (ADDR_W > 17) ? ADDR_W : 17;

    localparam int CELL_W   = 8;
    localparam int FIELD_W  = 16;
    localparam int STRIDE_W = 17;
    // error term grows by at most 65535 per step over at most 65535 steps
    localparam int ERR_W    = 33;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_MAJOR,
        WS_TEST_A,
        WS_TEST_B,
        WS_DONE
    } walk_state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] major_count;
        logic [FIELD_W-1:0] minor_count;
        logic [FIELD_W-1:0] initial_error;
        logic [ADDR_W-1:0]  major_off;
        logic [ADDR_W-1:0]  minor_off;
        logic [ADDR_W-1:0]  start_pos;
        logic [FIELD_W-1:0] max_steps;
    } cast_cmd_t;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] end_index;
    } cast_res_t;

    // unsigned 16-bit index to a grid address
    function automatic logic [ADDR_W-1:0] index_to_addr(input logic [FIELD_W-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[ADDR_W-1:0];
    endfunction

    // signed stride to an offset modulo the grid size
    function automatic logic [ADDR_W-1:0] stride_to_off(input logic [STRIDE_W-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(signed'(v));
        return t[ADDR_W-1:0];
    endfunction

    // low 16 bits of a grid address
    function automatic logic [FIELD_W-1:0] addr_to_index(input logic [ADDR_W-1:0] a);
        logic [EXT_W-1:0] t;
        t = EXT_W'(a);
        return t[FIELD_W-1:0];
    endfunction

endpackage

[rtl/core/grid_line_obstacle_check.sv]
// ----------------------------------------------------------------------------
// grid_line_obstacle_check
// occupancy grid with write items and bresenham line casts that stop on the
// first occupied cell
// ----------------------------------------------------------------------------
// A write transaction stores one byte cell and returns nothing. A cast
// transaction raises m_tvalid after it is accepted, once its walk ends: each
// major-axis step tests one cell and each minor-axis step one more, the walk
// ending early at the first occupied cell, and every cell test is one read
// of the grid memory, which has a registered read. No transaction is accepted
// while a cast walks. The grid memory has no reset: cells must be written
// before a cast reads them. A finished result waits in an output register, so
// the next transaction is accepted while it is still pending.
module grid_line_obstacle_check
    import glo_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CELL_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cell_index, cell_value, major_count, minor_count, initial_error,
    // major_stride, minor_stride, start_index, max_steps, zero pad
    input  logic [143:0]        s_tdata,
    // action
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit, end_index, zero pad
    output logic [23:0]         m_tdata
);

    logic [CELL_W-1:0] occupied_value_reg;
    logic              m_tvalid_reg;
    cast_res_t         m_res_reg;

    logic              accept;
    logic              cmd_valid;
    logic              cmd_ready;
    cast_cmd_t         cmd;
    logic              res_valid;
    logic              res_ready;
    cast_res_t         res;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    assign s_tready  = cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign cmd_valid = accept && (s_tuser == ACT_CAST);
    assign wr_en     = accept && (s_tuser == ACT_WRITE);

    assign cmd.major_count   = s_tdata[39:24];
    assign cmd.minor_count   = s_tdata[55:40];
    assign cmd.initial_error = s_tdata[71:56];
    assign cmd.major_off     = stride_to_off(s_tdata[88:72]);
    assign cmd.minor_off     = stride_to_off(s_tdata[105:89]);
    assign cmd.start_pos     = index_to_addr(s_tdata[121:106]);
    assign cmd.max_steps     = s_tdata[137:122];

    glo_ram #(
        .WIDTH (CELL_W),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (index_to_addr(s_tdata[15:0])),
        .wr_data (s_tdata[23:16]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    glo_walker u_walker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .occupied_value (occupied_value_reg),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_value_reg <= 8'd100;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                occupied_value_reg <= cfg_wr_data;
            end
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_res_reg.end_index, m_res_reg.hit};

endmodule

[rtl/core/glo_ram.sv]
// ----------------------------------------------------------------------------
// glo_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module glo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/glo_walker.sv]
// ----------------------------------------------------------------------------
// glo_walker
// line walk sequencer: steps the index and error term, reads each cell
// ----------------------------------------------------------------------------
module glo_walker
    import glo_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CELL_W-1:0] occupied_value,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cast_cmd_t         cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output cast_res_t         res,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [CELL_W-1:0] rd_data
);

    walk_state_t state_reg, state_next;

    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [FIELD_W-1:0] cnt_reg, cnt_next;
    logic [FIELD_W-1:0] steps_reg, steps_next;
    logic [FIELD_W-1:0] major_reg, major_next;
    logic [FIELD_W-1:0] minor_reg, minor_next;
    logic [ADDR_W-1:0]  astep_reg, astep_next;
    logic [ADDR_W-1:0]  bstep_reg, bstep_next;
    logic               hit_reg, hit_next;

    logic [FIELD_W-1:0] cmd_steps;
    logic               hit_now;
    logic               err_ge;
    logic               last_step;

    assign cmd_steps = (cmd.max_steps < cmd.major_count) ? cmd.max_steps : cmd.major_count;
    assign hit_now   = (rd_data == occupied_value);
    assign err_ge    = (err_reg >= ERR_W'(major_reg));
    assign last_step = ((cnt_reg + 16'd1) == steps_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            WS_IDLE: begin
                if (cmd_valid) begin
                    state_next = (cmd_steps == '0) ? WS_DONE : WS_MAJOR;
                end
            end
            WS_MAJOR: begin
                state_next = WS_TEST_A;
            end
            WS_TEST_A: begin
                if (hit_now) begin
                    state_next = WS_DONE;
                end else if (err_ge) begin
                    state_next = WS_TEST_B;
                end else if (last_step) begin
                    state_next = WS_DONE;
                end else begin
                    state_next = WS_MAJOR;
                end
            end
            WS_TEST_B: begin
                state_next = (hit_now || last_step) ? WS_DONE : WS_MAJOR;
            end
            WS_DONE: begin
                if (res_ready) begin
                    state_next = WS_IDLE;
                end
            end
            default: state_next = WS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pos_next   = pos_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        astep_next = astep_reg;
        bstep_next = bstep_reg;
        hit_next   = hit_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_reg;
        unique case (state_reg)
            WS_IDLE: begin
                if (cmd_valid) begin
                    pos_next   = cmd.start_pos;
                    err_next   = ERR_W'(cmd.initial_error);
                    cnt_next   = '0;
                    steps_next = cmd_steps;
                    major_next = cmd.major_count;
                    minor_next = cmd.minor_count;
                    astep_next = cmd.major_off;
                    bstep_next = cmd.minor_off;
                    hit_next   = 1'b0;
                end
            end
            WS_MAJOR: begin
                pos_next = pos_reg + astep_reg;
                err_next = err_reg + ERR_W'(minor_reg);
                rd_en    = 1'b1;
                rd_addr  = pos_next;
            end
            WS_TEST_A: begin
                if (hit_now) begin
                    hit_next = 1'b1;
                end else if (err_ge) begin
                    pos_next = pos_reg + bstep_reg;
                    err_next = err_reg - ERR_W'(major_reg);
                    rd_en    = 1'b1;
                    rd_addr  = pos_next;
                end else begin
                    cnt_next = cnt_reg + 16'd1;
                end
            end
            WS_TEST_B: begin
                if (hit_now) begin
                    hit_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 16'd1;
                end
            end
            WS_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        err_reg   <= err_next;
        cnt_reg   <= cnt_next;
        steps_reg <= steps_next;
        major_reg <= major_next;
        minor_reg <= minor_next;
        astep_reg <= astep_next;
        bstep_reg <= bstep_next;
        hit_reg   <= hit_next;
    end

    assign cmd_ready     = (state_reg == WS_IDLE);
    assign res_valid     = (state_reg == WS_DONE);
    assign res.hit       = hit_reg;
    assign res.end_index = addr_to_index(pos_reg);

`ifndef NO_ASSERTIONS
    a_zero_len_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd_ready && (cmd_steps == '0)) |=> (res_valid && !res.hit))
        else $error("zero length cast did not finish as a miss");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == WS_MAJOR) || (state_reg == WS_TEST_A) || (state_reg == WS_TEST_B))
        |-> (cnt_reg < steps_reg))
        else $error("step count ran past the step limit");

    a_hit_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (((state_reg == WS_TEST_A) || (state_reg == WS_TEST_B)) && hit_now)
        |=> (res_valid && res.hit && (pos_reg == $past(pos_reg))))
        else $error("occupied cell not reported at the tested index");

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |-> !res_valid)
        else $error("result offered while idle");
`endif

endmodule
